// ===== rtl/packet_sequence_xor_checker_core_assert.svh =====
// Assertion macros shared by the checker of the sequenced packet receiver.
`ifndef PACKET_SEQUENCE_XOR_CHECKER_CORE_ASSERT_SVH
`define PACKET_SEQUENCE_XOR_CHECKER_CORE_ASSERT_SVH

// Check that an implication holds at every clock edge outside reset.
`define PSXC_ASSERT_IMPL(label, clk, rst_n, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("packet checker assertion failed");

// Check that a condition never holds outside reset.
`define PSXC_ASSERT_NEVER(label, clk, rst_n, cond) \
    label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
        else $error("packet checker forbidden condition seen");

`endif

// ===== rtl/psxc_pkg.sv =====
// Package with types and constants of the sequenced packet receiver.
package psxc_pkg;

    localparam int unsigned BYTE_W   = 8;
    localparam int unsigned POS_W    = 9;
    localparam int unsigned COUNT_W  = 16;
    localparam int unsigned CFG_W    = 16;
    localparam int unsigned STATUS_W = 2;

    localparam logic [POS_W-1:0]   POS_SATURATE    = 9'd257;
    localparam logic [BYTE_W-1:0]  PAYLOAD_LEN_RST = 8'd240;
    localparam logic [COUNT_W-1:0] TOTAL_RST       = 16'd640;
    localparam logic [COUNT_W-1:0] COUNT_MAX       = 16'hFFFF;

    typedef enum logic [STATUS_W-1:0] {
        ST_ACCEPTED = 2'd0,
        ST_ERROR    = 2'd1,
        ST_IGNORED  = 2'd2
    } t_status;

    typedef enum logic {
        CFG_PAYLOAD_LEN = 1'b0,
        CFG_TOTAL       = 1'b1
    } t_cfg_idx;

    typedef struct packed {
        t_status              status;
        logic [BYTE_W-1:0]    sequence_res;
        logic [COUNT_W-1:0]   accepted_total;
        logic                 all_good;
        logic                 complete;
    } t_result;

endpackage

// ===== rtl/psxc_rx_if.sv =====
// Stream interface carrying received bytes into the packet receiver.
interface psxc_rx_if;
    import psxc_pkg::*;

    logic              valid;
    logic              ready;
    logic [BYTE_W-1:0] rx_byte;
    logic              end_of_packet;

    modport source (output valid, output rx_byte, output end_of_packet, input ready);
    modport sink   (input valid, input rx_byte, input end_of_packet, output ready);
endinterface

// ===== rtl/psxc_res_if.sv =====
// Stream interface carrying per-packet results out of the packet receiver.
interface psxc_res_if;
    import psxc_pkg::*;

    logic                valid;
    logic                ready;
    logic [STATUS_W-1:0] status;
    logic [BYTE_W-1:0]   sequence_res;
    logic [COUNT_W-1:0]  accepted_total;
    logic                all_good;
    logic                complete;

    modport source (output valid, output status, output sequence_res,
                    output accepted_total, output all_good, output complete,
                    input ready);
    modport sink   (input valid, input status, input sequence_res,
                    input accepted_total, input all_good, input complete,
                    output ready);
endinterface

// ===== rtl/psxc_engine.sv =====
// Packet parsing state and per-byte next-state logic of the receiver.
module psxc_engine import psxc_pkg::*; (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_accept,
    input  logic [BYTE_W-1:0]  i_rx_byte,
    input  logic               i_end_of_packet,
    input  logic [BYTE_W-1:0]  i_payload_len,
    input  logic [COUNT_W-1:0] i_total,
    output logic               o_res_valid,
    output t_result            o_res
);

    logic [POS_W-1:0]   r_pos, n_pos;
    logic [BYTE_W-1:0]  r_xor, n_xor;
    logic [BYTE_W-1:0]  r_seq, n_seq;
    logic [COUNT_W-1:0] r_count, n_count;
    logic               r_no_err, n_no_err;
    logic               r_finished, n_finished;

    logic               take;
    logic               first;
    logic [BYTE_W-1:0]  xor_upd;
    logic [BYTE_W-1:0]  seq_upd;
    logic               len_ok;
    logic               good;
    t_status            status;

    always_comb begin
        take    = i_accept && !r_finished;
        first   = (r_pos == '0);
        xor_upd = first ? '0 : (r_xor ^ i_rx_byte);
        seq_upd = first ? i_rx_byte : r_seq;
        len_ok  = (r_pos == ({1'b0, i_payload_len} + POS_W'(1)));
        good    = (xor_upd == '0) && (seq_upd == r_count[BYTE_W-1:0]);

        n_pos      = r_pos;
        n_xor      = r_xor;
        n_seq      = r_seq;
        n_count    = r_count;
        n_no_err   = r_no_err;
        n_finished = r_finished;
        status     = ST_IGNORED;

        if (take) begin
            if (!i_end_of_packet) begin
                n_xor = xor_upd;
                n_seq = seq_upd;
                if (r_pos < POS_SATURATE) begin
                    n_pos = r_pos + POS_W'(1);
                end
            end else begin
                // Restart the packet and settle the verdict.
                n_pos = '0;
                n_xor = '0;
                n_seq = '0;
                if (len_ok) begin
                    if (good) begin
                        status = ST_ACCEPTED;
                        if (r_count != COUNT_MAX) begin
                            n_count = r_count + COUNT_W'(1);
                        end
                    end else begin
                        status   = ST_ERROR;
                        n_no_err = 1'b0;
                    end
                    n_finished = (n_count >= i_total);
                end
            end
        end

        o_res_valid          = take && i_end_of_packet;
        o_res.status         = status;
        o_res.sequence_res   = seq_upd;
        o_res.accepted_total = n_count;
        o_res.all_good       = n_no_err;
        o_res.complete       = n_finished;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos      <= '0;
            r_xor      <= '0;
            r_seq      <= '0;
            r_count    <= '0;
            r_no_err   <= 1'b1;
            r_finished <= 1'b0;
        end else begin
            r_pos      <= n_pos;
            r_xor      <= n_xor;
            r_seq      <= n_seq;
            r_count    <= n_count;
            r_no_err   <= n_no_err;
            r_finished <= n_finished;
        end
    end

endmodule

// ===== rtl/packet_sequence_xor_checker_core.sv =====
// Top level of the sequenced packet receiver with XOR checksum.
// Usage:
//   i_rx carries one received byte per word, with end_of_packet set on the
//   last byte of each packet (sequence byte, payload, checksum byte).
//   o_res carries one word per packet end: status, the packet's sequence
//   byte, the accepted count, the sticky all-good flag and completion.
//   i_cfg_we/i_cfg_idx/i_cfg_data write payload length (index 0) and total
//   packet count (index 1); write only while the block is idle.
// Throughput: one byte per cycle, sustained; a byte is taken in the same
//   cycle it is offered when the result register is free or draining.
// Result: the word appears in the cycle after the end-of-packet byte
//   is accepted, held in a single output register.
// Stall: while o_res is stalled with a word pending, i_rx.ready drops and
//   input bytes wait; a word in flight is never dropped or repeated.
// Reset: i_rst_n (synchronous, active low) clears the parse state, count and
//   completion, sets all-good, and restores payload length 240 and total 640.
// After completion every byte is accepted and dropped with no result.
module packet_sequence_xor_checker_core import psxc_pkg::*; (
    input  logic               i_clk,
    input  logic               i_rst_n,
    psxc_rx_if.sink            i_rx,
    psxc_res_if.source         o_res,
    input  logic               i_cfg_we,
    input  logic               i_cfg_idx,
    input  logic [CFG_W-1:0]   i_cfg_data
);

    logic [BYTE_W-1:0]  r_payload_len;
    logic [COUNT_W-1:0] r_total;

    logic               r_out_valid;
    t_result            r_out;

    logic               accept;
    logic               res_valid;
    t_result            res;

    // Take a byte whenever the output register can take a new word.
    assign i_rx.ready = !r_out_valid || o_res.ready;
    assign accept     = i_rx.valid && i_rx.ready;

    // Hold the configuration registers; the user must write them only while idle, as the block does not enforce it.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_payload_len <= PAYLOAD_LEN_RST;
            r_total       <= TOTAL_RST;
        end else if (i_cfg_we) begin
            unique case (t_cfg_idx'(i_cfg_idx))
                CFG_PAYLOAD_LEN: r_payload_len <= i_cfg_data[BYTE_W-1:0];
                CFG_TOTAL:       r_total       <= i_cfg_data[COUNT_W-1:0];
                default:         r_total       <= r_total;
            endcase
        end
    end

    psxc_engine u_engine (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_accept        (accept),
        .i_rx_byte       (i_rx.rx_byte),
        .i_end_of_packet (i_rx.end_of_packet),
        .i_payload_len   (r_payload_len),
        .i_total         (r_total),
        .o_res_valid     (res_valid),
        .o_res           (res)
    );

    // Advance the result register when free or drained; hold it otherwise.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_rx.ready) begin
            r_out_valid <= res_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_rx.ready && res_valid) begin
            r_out <= res;
        end
    end

    assign o_res.valid          = r_out_valid;
    assign o_res.status         = r_out.status;
    assign o_res.sequence_res   = r_out.sequence_res;
    assign o_res.accepted_total = r_out.accepted_total;
    assign o_res.all_good       = r_out.all_good;
    assign o_res.complete       = r_out.complete;

endmodule

// ===== rtl/psxc_checker.sv =====
// Port-level assertion checker for the sequenced packet receiver, with its bind.
`include "packet_sequence_xor_checker_core_assert.svh"

module psxc_checker import psxc_pkg::*; (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_res_valid,
    input  logic                i_res_ready,
    input  logic [STATUS_W-1:0] i_status,
    input  logic [COUNT_W-1:0]  i_accepted_total,
    input  logic                i_all_good,
    input  logic                i_complete
);

    `PSXC_ASSERT_IMPL(a_res_hold, i_clk, i_rst_n, (i_res_valid && !i_res_ready) |=> (i_res_valid && $stable(i_status) && $stable(i_accepted_total)))
    `PSXC_ASSERT_NEVER(a_err_keeps_good, i_clk, i_rst_n, i_res_valid && (i_status == ST_ERROR) && i_all_good)
    `PSXC_ASSERT_NEVER(a_complete_ignored, i_clk, i_rst_n, i_res_valid && i_complete && (i_status == ST_IGNORED))
    `PSXC_ASSERT_NEVER(a_accept_zero, i_clk, i_rst_n, i_res_valid && (i_status == ST_ACCEPTED) && (i_accepted_total == '0))
    `PSXC_ASSERT_IMPL(a_silent_after_done, i_clk, i_rst_n, (i_res_valid && i_res_ready && i_complete) |=> !i_res_valid)

endmodule

bind packet_sequence_xor_checker_core psxc_checker u_psxc_checker (
    .i_clk            (i_clk),
    .i_rst_n          (i_rst_n),
    .i_res_valid      (o_res.valid),
    .i_res_ready      (o_res.ready),
    .i_status         (o_res.status),
    .i_accepted_total (o_res.accepted_total),
    .i_all_good       (o_res.all_good),
    .i_complete       (o_res.complete)
);
